>>> src/lfu_cache_with_pinning_macros.svh
// Assertion macros shared by the LFU cache RTL files.
`ifndef LFU_CACHE_WITH_PINNING_MACROS_SVH
`define LFU_CACHE_WITH_PINNING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LCP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled during reset.
`define LCP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LCP_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define LCP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> src/lcp_pkg.sv
// Package with types, codes and constants of the LFU cache with pinning.
`timescale 1ns / 1ps
`default_nettype none
package lcp_pkg;
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;
    localparam int IDX_W        = 8;
    localparam int CNT_W        = 9;
    localparam logic [15:0] USAGE_MAX = 16'hFFFF;
    localparam logic [7:0]  PINS_MAX  = 8'hFF;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_USE     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_BAD     = 2'd3;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_INSERT  = 3'd1;
    localparam logic [2:0] ST_EVICT   = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_SCAN
    } fsm_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key;
        logic [3:0]  slot;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic        evicted_flag;
        logic [63:0] evicted_key;
        logic [15:0] use_count;
        logic [7:0]  pin_count;
    } rsp_t;

    // Command as seen by every cell.
    typedef struct packed {
        logic        is_acq;
        logic [63:0] key;
        logic [3:0]  slot;
    } bcast_t;

    // Entry write broadcast to the cells.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             load_key;
        logic [63:0]      key;
        logic             valid;
        logic [15:0]      usage;
        logic [7:0]       pins;
    } wr_t;

    // Running search result handed from cell to cell.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count;
        logic             vic_found;
        logic [IDX_W-1:0] vic_idx;
        logic [15:0]      vic_usage;
        logic [63:0]      vic_key;
        logic             sel_valid;
        logic [15:0]      sel_usage;
        logic [7:0]       sel_pins;
    } sum_t;
endpackage
`default_nettype wire

>>> src/lcp_cell.sv
// One table entry of the LFU cache, with its stage of the search chain.
`timescale 1ns / 1ps
`default_nettype none
module lcp_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = lcp_pkg::KEY_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  lcp_pkg::bcast_t    bc,
    input  lcp_pkg::wr_t       wr,
    input  lcp_pkg::sum_t      sum_in,
    output lcp_pkg::sum_t      sum_out
);
    import lcp_pkg::*;

    localparam logic [IDX_W-1:0] HERE = IDX_W'(INDEX);

    logic                valid_reg;
    logic [15:0]         usage_reg;
    logic [7:0]          pins_reg;
    logic [KEY_BITS-1:0] key_reg;
    sum_t                sum_reg;
    sum_t                sum_next;
    logic                wr_here;

    assign wr_here = wr.en && (wr.idx == HERE);

    // Entry control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            usage_reg <= '0;
            pins_reg  <= '0;
        end
        else if (wr_here)
        begin
            valid_reg <= wr.valid;
            usage_reg <= wr.usage;
            pins_reg  <= wr.pins;
        end
    end

    // The key is only read while the entry is valid, so it has no reset.
    always_ff @(posedge clk)
    begin
        if (wr_here && wr.load_key)
        begin
            key_reg <= wr.key[KEY_BITS-1:0];
        end
    end

    // Fold this entry into the running search result.
    always_comb
    begin
        sum_next = sum_in;
        if (valid_reg)
        begin
            sum_next.count = sum_in.count + CNT_W'(1);
            if (bc.is_acq && !sum_in.hit && (key_reg == bc.key[KEY_BITS-1:0]))
            begin
                sum_next.hit       = 1'b1;
                sum_next.hit_idx   = HERE;
                sum_next.sel_valid = 1'b1;
                sum_next.sel_usage = usage_reg;
                sum_next.sel_pins  = pins_reg;
            end
            if ((pins_reg == 8'd0) && (!sum_in.vic_found || (usage_reg < sum_in.vic_usage)))
            begin
                sum_next.vic_found = 1'b1;
                sum_next.vic_idx   = HERE;
                sum_next.vic_usage = usage_reg;
                sum_next.vic_key   = 64'(key_reg);
            end
        end
        else if (!sum_in.free_found)
        begin
            sum_next.free_found = 1'b1;
            sum_next.free_idx   = HERE;
        end
        if (!bc.is_acq && ({{(IDX_W-4){1'b0}}, bc.slot} == HERE))
        begin
            sum_next.sel_valid = valid_reg;
            sum_next.sel_usage = usage_reg;
            sum_next.sel_pins  = pins_reg;
        end
    end

    // Hand the result to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

    `include "lfu_cache_with_pinning_macros.svh"
    `LCP_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, sum_next.count <= CNT_W'(INDEX + 1))
    `LCP_ASSERT_IMPLY(a_free_invalid, clk, rst_n, sum_next.free_found && !sum_in.free_found, !valid_reg)
    `LCP_ASSERT_NEXT(a_unpinned_vic, clk, rst_n, sum_next.vic_idx == HERE && sum_next.vic_found && !(sum_in.vic_found && sum_in.vic_idx == HERE) && !wr_here, pins_reg == 8'd0)
endmodule
`default_nettype wire

>>> src/lfu_cache_with_pinning.sv
// Top level of the LFU cache with pinning: command sequencer over a chain of entry cells.
// Usage: a command (acquire by key, use slot, release slot) is a transfer on the cmd
// channel (cmd_valid high, cmd_stall low). Each command gives exactly one result on the
// rsp channel, a transfer when rsp_valid is high and rsp_stall is low.
// The table lives in a chain of ENTRIES cells; the search result moves one cell per
// cycle, and a new command is taken the cycle after the result is loaded. The command is
// registered, and its search walks the whole cell chain while the scan counter counts up
// to ENTRIES; the result register loads at the end of the scan.
// While the result register still holds an untaken result, the next result waits at the
// end of its scan and cmd_stall stays high; the result register holds steady under stall.
// Reset empties the table (all entries invalid, counts zero), sets capacity to 16 and
// drops any pending result. The user writes capacity through APB at address 0 only while
// the block is idle (it does not check this); 0 acts as 1, above ENTRIES as ENTRIES.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_with_pinning #(
    parameter int ENTRIES  = lcp_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lcp_pkg::KEY_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  lcp_pkg::cmd_t    cmd_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output lcp_pkg::rsp_t    rsp_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lcp_pkg::*;

    localparam int SCAN_W = $clog2(ENTRIES + 1);

    fsm_t              state_reg;
    fsm_t              state_next;
    logic [SCAN_W-1:0] cnt_reg;
    logic [SCAN_W-1:0] cnt_next;
    cmd_t              cmd_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [4:0]        cap_reg;
    logic [CNT_W-1:0]  cap_eff;
    logic              accept;
    logic              done;
    logic              out_free;
    bcast_t            bc;
    wr_t               wr;
    sum_t              sum_w [0:ENTRIES];
    sum_t              s;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[4:0];
        end
    end
    assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, cap_reg} : 32'd0;

    always_comb
    begin
        cap_eff = CNT_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        if (cap_eff > CNT_W'(ENTRIES))
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
    end

    // Handshake and sequencing conditions.
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = (state_reg == FSM_IDLE) && cmd_valid;
    assign done     = (state_reg == FSM_SCAN) && (cnt_reg == SCAN_W'(ENTRIES)) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (done)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_stall = 1'b1;
        cnt_next  = cnt_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                cmd_stall = 1'b0;
                cnt_next  = '0;
            end
            FSM_SCAN:
            begin
                if (cnt_reg != SCAN_W'(ENTRIES))
                begin
                    cnt_next = cnt_reg + SCAN_W'(1);
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_data;
        end
        if (done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid_next = done ? 1'b1 : (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;
    assign rsp_data       = rsp_reg;

    // Command broadcast and cell chain.
    assign bc.is_acq = (cmd_reg.command == CMD_ACQUIRE);
    assign bc.key    = cmd_reg.key;
    assign bc.slot   = cmd_reg.slot;
    assign sum_w[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lcp_cell #(
            .INDEX    (i),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .wr      (wr),
            .sum_in  (sum_w[i]),
            .sum_out (sum_w[i+1])
        );
    end

    assign s = sum_w[ENTRIES];

    // Decision on the finished search: result and entry write.
    always_comb
    begin
        rsp_next          = '0;
        wr                = '0;
        wr.key            = 64'(cmd_reg.key[KEY_BITS-1:0]);
        rsp_next.slot_index = cmd_reg.slot;
        if (bc.is_acq)
        begin
            if (s.hit)
            begin
                rsp_next.slot_index = s.hit_idx[3:0];
                rsp_next.use_count  = s.sel_usage;
                if (s.sel_pins == PINS_MAX)
                begin
                    rsp_next.status    = ST_ERROR;
                    rsp_next.pin_count = s.sel_pins;
                end
                else
                begin
                    rsp_next.status    = ST_HIT;
                    rsp_next.pin_count = s.sel_pins + 8'd1;
                    wr.en    = 1'b1;
                    wr.idx   = s.hit_idx;
                    wr.valid = 1'b1;
                    wr.usage = s.sel_usage;
                    wr.pins  = s.sel_pins + 8'd1;
                end
            end
            else if ((s.count < cap_eff) && s.free_found)
            begin
                rsp_next.status     = ST_INSERT;
                rsp_next.slot_index = s.free_idx[3:0];
                rsp_next.pin_count  = 8'd1;
                wr.en       = 1'b1;
                wr.idx      = s.free_idx;
                wr.load_key = 1'b1;
                wr.valid    = 1'b1;
                wr.pins     = 8'd1;
            end
            else if (!s.vic_found)
            begin
                rsp_next.status     = ST_REFUSED;
                rsp_next.slot_index = 4'd0;
            end
            else
            begin
                rsp_next.status       = ST_EVICT;
                rsp_next.slot_index   = s.vic_idx[3:0];
                rsp_next.evicted_flag = 1'b1;
                rsp_next.evicted_key  = s.vic_key;
                rsp_next.pin_count    = 8'd1;
                wr.en       = 1'b1;
                wr.idx      = s.vic_idx;
                wr.load_key = 1'b1;
                wr.valid    = 1'b1;
                wr.pins     = 8'd1;
            end
        end
        else if ((cmd_reg.command != CMD_USE && cmd_reg.command != CMD_RELEASE)
                 || !s.sel_valid)
        begin
            rsp_next.status = ST_ERROR;
        end
        else if (cmd_reg.command == CMD_USE)
        begin
            rsp_next.status    = ST_HIT;
            rsp_next.use_count = (s.sel_usage == USAGE_MAX) ? s.sel_usage
                                                             : s.sel_usage + 16'd1;
            rsp_next.pin_count = s.sel_pins;
            wr.en    = 1'b1;
            wr.idx   = {{(IDX_W-4){1'b0}}, cmd_reg.slot};
            wr.valid = 1'b1;
            wr.usage = rsp_next.use_count;
            wr.pins  = s.sel_pins;
        end
        else if (s.sel_pins == 8'd0)
        begin
            rsp_next.status    = ST_ERROR;
            rsp_next.use_count = s.sel_usage;
        end
        else
        begin
            rsp_next.status    = ST_HIT;
            rsp_next.use_count = s.sel_usage;
            rsp_next.pin_count = s.sel_pins - 8'd1;
            wr.en    = 1'b1;
            wr.idx   = {{(IDX_W-4){1'b0}}, cmd_reg.slot};
            wr.valid = 1'b1;
            wr.usage = s.sel_usage;
            wr.pins  = s.sel_pins - 8'd1;
        end
        wr.en = wr.en && done;
    end

    `include "lfu_cache_with_pinning_macros.svh"
    `LCP_ASSERT_IMPLY(a_stall_in_scan, clk, rst_n, state_reg == FSM_SCAN, cmd_stall)
    `LCP_ASSERT_IMPLY(a_done_full_scan, clk, rst_n, wr.en, cnt_reg == SCAN_W'(ENTRIES))
    `LCP_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, state_reg == FSM_SCAN && cnt_reg == '0)
    `LCP_ASSERT_NEXT(a_done_gives_result, clk, rst_n, done, rsp_valid && state_reg == FSM_IDLE)
endmodule
`default_nettype wire
